>>> hdl/rc4kiv_pkg.sv
// Shared types and constants for the RC4 keystream core with per-frame IV.
// No dependencies; used by the engine, the top level and the checker.

package rc4kiv_pkg;

  localparam int unsigned KeyW      = 40;
  localparam int unsigned IvW       = 64;
  localparam int unsigned KeyBytes  = KeyW / 8;
  localparam int unsigned IvBytes   = IvW / 8;
  localparam int unsigned SchedLen  = KeyBytes + IvBytes;  // 13
  localparam int unsigned PermDepth = 256;
  localparam int unsigned AddrW     = $clog2(PermDepth);
  localparam int unsigned SchedIdxW = $clog2(SchedLen);

  // command codes
  localparam logic CmdRekey = 1'b0;
  localparam logic CmdData  = 1'b1;

  typedef struct packed {
    logic       command;
    logic [63:0] frame_iv;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] keystream_byte;
    logic [7:0] result_byte;
    logic       not_keyed;
  } out_item_t;

  // engine status towards the top level
  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_status_t;

endpackage

>>> hdl/rc4kiv_engine.sv
// RC4 engine: permutation memory, index registers and the sequencer that
// drives key scheduling and keystream generation through one memory port pair.
// Depends on rc4kiv_pkg.

module rc4kiv_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  rc4kiv_pkg::in_item_t   item_i,
  input  logic [39:0]            key_i,
  input  logic                   res_ready_i,
  output rc4kiv_pkg::eng_status_t status_o,
  output rc4kiv_pkg::out_item_t  res_o
);

  typedef enum logic [9:0] {
    StIdle = 10'b0000000001,
    StInit = 10'b0000000010,
    StKa   = 10'b0000000100,
    StKb   = 10'b0000001000,
    StKc   = 10'b0000010000,
    StKd   = 10'b0000100000,
    StPb   = 10'b0001000000,
    StPc   = 10'b0010000000,
    StPd   = 10'b0100000000,
    StOut  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0] mem [rc4kiv_pkg::PermDepth];
  logic       we;
  logic [rc4kiv_pkg::AddrW-1:0] waddr, raddr;
  logic [7:0] wdata;
  logic [7:0] rdata_q;

  logic [rc4kiv_pkg::SchedLen-1:0][7:0] sched_q;
  logic [rc4kiv_pkg::SchedIdxW-1:0]     k_q;
  logic [rc4kiv_pkg::AddrW-1:0]         n_q, i_q, j_q;
  logic [7:0]  si_q, sj_q, data_q, ks_q;
  logic        keyed_q, nk_q, pe_q;
  logic [7:0]  j_ksa, j_prga, i_next;

  assign i_next = i_q + 8'd1;
  assign j_ksa  = j_q + rdata_q + sched_q[k_q];
  assign j_prga = j_q + rdata_q;

  // permutation memory, write-first on an address clash
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
  end

  always_comb begin
    state_d = state_q;
    we      = 1'b0;
    waddr   = n_q;
    wdata   = n_q;
    raddr   = i_next;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          if (item_i.command == rc4kiv_pkg::CmdRekey) state_d = StInit;
          else if (keyed_q)                           state_d = StPb;
          else                                        state_d = StOut;
        end
      end
      StInit: begin
        we = 1'b1;
        if (n_q == 8'hFF) state_d = StKa;
      end
      StKa: begin
        raddr   = n_q;
        state_d = StKb;
      end
      StKb: begin
        raddr   = j_ksa;
        state_d = StKc;
      end
      StKc: begin
        we      = 1'b1;
        wdata   = rdata_q;
        state_d = StKd;
      end
      StKd: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = si_q;
        raddr = n_q + 8'd1;
        state_d = (n_q == 8'hFF) ? StIdle : StKb;
      end
      StPb: begin
        raddr   = j_prga;
        state_d = StPc;
      end
      StPc: begin
        we      = 1'b1;
        waddr   = i_q;
        wdata   = rdata_q;
        state_d = StPd;
      end
      StPd: begin
        we      = 1'b1;
        waddr   = j_q;
        wdata   = si_q;
        raddr   = si_q + sj_q;
        state_d = StOut;
      end
      StOut: begin
        if (res_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      keyed_q <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      k_q     <= '0;
      nk_q    <= 1'b0;
      pe_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pe_q    <= (state_q == StPd);
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            if (item_i.command == rc4kiv_pkg::CmdRekey) begin
              n_q <= '0;
            end else begin
              nk_q <= !keyed_q;
              if (keyed_q) i_q <= i_next;
            end
          end
        end
        StInit: begin
          n_q <= n_q + 8'd1;
          if (n_q == 8'hFF) begin
            j_q <= '0;
            k_q <= '0;
          end
        end
        StKb: j_q <= j_ksa;
        StKd: begin
          n_q <= n_q + 8'd1;
          k_q <= (k_q == rc4kiv_pkg::SchedIdxW'(rc4kiv_pkg::SchedLen - 1))
                 ? '0 : k_q + 1'b1;
          if (n_q == 8'hFF) begin
            i_q     <= '0;
            j_q     <= '0;
            keyed_q <= 1'b1;
          end
        end
        StPb: j_q <= j_prga;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      data_q <= item_i.data_byte;
      ks_q   <= '0;
      if (item_i.command == rc4kiv_pkg::CmdRekey) begin
        sched_q <= {item_i.frame_iv, key_i};
      end
    end
    if (state_q == StKb || state_q == StPb) si_q <= rdata_q;
    if (state_q == StPc) sj_q <= rdata_q;
    if (pe_q) ks_q <= rdata_q;
  end

  // keystream byte arrives in the first StOut cycle, so pick it straight up then
  logic [7:0] ks_out;
  assign ks_out = pe_q ? rdata_q : ks_q;

  assign status_o.idle      = (state_q == StIdle);
  assign status_o.res_valid = (state_q == StOut);
  assign res_o.keystream_byte = nk_q ? 8'h00 : ks_out;
  assign res_o.result_byte    = nk_q ? 8'h00 : (ks_out ^ data_q);
  assign res_o.not_keyed      = nk_q;

endmodule

>>> hdl/rc4_keystream_with_iv_core.sv
// RC4 keystream core with per-frame IV: top level with key register,
// input handshake and output register. Depends on rc4kiv_pkg, rc4kiv_engine.

// Takes one item at a time and stalls its input until that item is done. A
// data item stalls it through StPb, StPc, StPd and StOut (only StOut before
// any rekey), then its result is registered at the output; the stall and the
// result both wait while a stalled result holds the output register. A rekey
// gives no result and stalls the input while it loads the identity
// permutation, fetches the first entry, then runs each key scheduling step
// through StKb, StKc and StKd on the single read and single write port of the
// permutation memory, which also bounds a data item (three reads and two
// writes per byte). The result sits in an output register, so a new item can
// be taken while it waits. The user writes cipher_key (cfg_we_i/cfg_wdata_i)
// only while idle, which the block does not enforce; each rekey samples it.

module rc4_keystream_with_iv_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [39:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rc4kiv_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rc4kiv_pkg::out_item_t out_item_o
);

  logic [39:0]             key_q;
  logic                    out_valid_q;
  rc4kiv_pkg::out_item_t   out_item_q;
  rc4kiv_pkg::eng_status_t eng_status;
  rc4kiv_pkg::out_item_t   eng_res;
  logic                    slot_free, start;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !eng_status.idle;
  assign start     = in_valid_i && eng_status.idle;

  rc4kiv_engine u_engine (
    .clk_i,
    .rst_ni,
    .start_i     (start),
    .item_i      (in_item_i),
    .key_i       (key_q),
    .res_ready_i (slot_free),
    .status_o    (eng_status),
    .res_o       (eng_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) key_q <= cfg_wdata_i;
      if (slot_free) out_valid_q <= eng_status.res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && eng_status.res_valid) out_item_q <= eng_res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> hdl/rc4kiv_checker.sv
// Port-level checks for rc4_keystream_with_iv_core, bound to the top level.
// Depends on rc4kiv_pkg.

module rc4kiv_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input rc4kiv_pkg::in_item_t  in_item_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input rc4kiv_pkg::out_item_t out_item_o
);

  // a result waiting on the far side holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // unkeyed results carry zeros
  a_unkeyed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.not_keyed |->
      out_item_o.keystream_byte == 8'h00 && out_item_o.result_byte == 8'h00)
    else $error("unkeyed result not zero");

  // every transfer in keeps the engine busy for at least the next cycle
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  // a rekey never produces a result straight after its transfer
  a_rekey_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.command == rc4kiv_pkg::CmdRekey
      && !out_valid_o |=> !out_valid_o)
    else $error("result after rekey");

endmodule

bind rc4_keystream_with_iv_core rc4kiv_checker u_checker (.*);

>>> tb/tb_rc4_keystream_with_iv_core.sv
// Self-checking testbench for rc4_keystream_with_iv_core: directed and random
// rekey/data traffic, checked against an RC4 keystream tracker kept in a class.
// Depends on rc4kiv_pkg and the core.
`timescale 1ns / 1ps

class rc4_keystream_tracker;
  bit [7:0]  perm [rc4kiv_pkg::PermDepth];
  bit [7:0]  idx_i;
  bit [7:0]  idx_j;
  bit        keyed;
  bit [39:0] cipher_key;
  rc4kiv_pkg::out_item_t expected_q [$];
  int unsigned mismatches;

  function void set_key(bit [39:0] k);
    cipher_key = k;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void run_key_schedule(bit [63:0] iv);
    bit [7:0] sched [rc4kiv_pkg::SchedLen];
    bit [7:0] j;
    bit [7:0] t;
    for (int n = 0; n < rc4kiv_pkg::KeyBytes; n++) sched[n] = cipher_key[8*n +: 8];
    for (int n = 0; n < rc4kiv_pkg::IvBytes; n++) begin
      sched[rc4kiv_pkg::KeyBytes + n] = iv[8*n +: 8];
    end
    for (int n = 0; n < rc4kiv_pkg::PermDepth; n++) perm[n] = n[7:0];
    j = 8'h00;
    for (int n = 0; n < rc4kiv_pkg::PermDepth; n++) begin
      j = j + perm[n] + sched[n % rc4kiv_pkg::SchedLen];
      t = perm[n];
      perm[n] = perm[j];
      perm[j] = t;
    end
    idx_i = 8'h00;
    idx_j = 8'h00;
    keyed = 1'b1;
  endfunction

  function bit [7:0] advance_generator();
    bit [7:0] t;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm[idx_i];
    t = perm[idx_i];
    perm[idx_i] = perm[idx_j];
    perm[idx_j] = t;
    return perm[8'(perm[idx_i] + perm[idx_j])];
  endfunction

  // called once per accepted input transfer
  function void note_input(rc4kiv_pkg::in_item_t it);
    rc4kiv_pkg::out_item_t exp_res;
    bit [7:0] ks;
    if (it.command == rc4kiv_pkg::CmdRekey) begin
      run_key_schedule(it.frame_iv);
    end else if (!keyed) begin
      exp_res.keystream_byte = 8'h00;
      exp_res.result_byte    = 8'h00;
      exp_res.not_keyed      = 1'b1;
      expected_q.insert(expected_q.size(), exp_res);
    end else begin
      ks = advance_generator();
      exp_res.keystream_byte = ks;
      exp_res.result_byte    = ks ^ it.data_byte;
      exp_res.not_keyed      = 1'b0;
      expected_q.insert(expected_q.size(), exp_res);
    end
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  task check_result(rc4kiv_pkg::out_item_t got);
    rc4kiv_pkg::out_item_t exp_res;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result %0h", got));
    end else begin
      exp_res = expected_q.pop_front();
      if (got.keystream_byte !== exp_res.keystream_byte)
        report($sformatf("keystream_byte got %0h want %0h",
                         got.keystream_byte, exp_res.keystream_byte));
      if (got.result_byte !== exp_res.result_byte)
        report($sformatf("result_byte got %0h want %0h",
                         got.result_byte, exp_res.result_byte));
      if (got.not_keyed !== exp_res.not_keyed)
        report($sformatf("not_keyed got %0b want %0b",
                         got.not_keyed, exp_res.not_keyed));
    end
  endtask
endclass

module tb_rc4_keystream_with_iv_core;

  localparam int RekeyBusy  = 1025;
  localparam int CycleLimit = 5_000_000;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        cfg_we   = 1'b0;
  logic [39:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  rc4kiv_pkg::in_item_t  in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rc4kiv_pkg::out_item_t out_item;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int unsigned cycles = 0;

  rc4_keystream_tracker tracker = new();

  rc4_keystream_with_iv_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_item);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(rc4kiv_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_input(it);
  endtask

  task automatic send_data(logic [7:0] d, logic [63:0] iv);
    rc4kiv_pkg::in_item_t it;
    it.command   = rc4kiv_pkg::CmdData;
    it.frame_iv  = iv;
    it.data_byte = d;
    send(it);
  endtask

  task automatic send_rekey(logic [63:0] iv, logic [7:0] d);
    rc4kiv_pkg::in_item_t it;
    it.command   = rc4kiv_pkg::CmdRekey;
    it.frame_iv  = iv;
    it.data_byte = d;
    send(it);
  endtask

  // sender holds off until every outstanding result has been transferred
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // a rekey may still be running after the last result, so give it time
  task automatic write_key(logic [39:0] k);
    drain();
    repeat (RekeyBusy + 100) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    tracker.set_key(k);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_iv();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) drain();
      if ($urandom_range(99) < 4) send_rekey(rand_iv(), 8'($urandom));
      else send_data(8'($urandom), {$urandom, $urandom});
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_key('0);

    send_idle_pct  = 16;
    recv_stall_pct = 70;
    // data before any rekey: zero result with the not-keyed flag
    send_data(8'h00, '0);
    send_data(8'hFF, '1);
    send_rekey('0, 8'hFF);
    send_data(8'h00, '0);
    send_data(8'hFF, '0);
    send_data(8'h5A, '1);
    send_rekey('1, 8'hA5);
    repeat (3) send_data(8'($urandom), {$urandom, $urandom});
    write_key('1);
    // new key is not used until the next rekey
    send_data(8'hC3, '0);
    send_rekey(64'h0123_4567_89AB_CDEF, 8'h00);
    repeat (4) send_data(8'($urandom), {$urandom, $urandom});
    send_rekey('0, 8'h00);
    send_rekey({$urandom, $urandom}, 8'hFF);
    send_data(8'h00, '1);
    send_data(8'hFF, '0);

    write_key({8'($urandom), $urandom});
    random_phase(300, 16, 70);
    write_key('1);
    random_phase(300, 70, 16);
    write_key({8'($urandom), $urandom});
    random_phase(300, 0, 0);

    drain();
    repeat (RekeyBusy + 100) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending()));
    if (tracker.mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
